// ----- design/lcr_pkg.sv -----
// lcr_pkg: shared constants and the command type of the column realigner
// used by the front, queue, back and top level files; no dependencies
`default_nettype none

package lcr_pkg;

   // tab stop spacing and command queue depth defaults
   localparam int TAB_STOP    = 8;
   localparam int QUEUE_DEPTH = 4;

   // space count of one command: padding is at most 63, a tab run at most TAB_STOP
   localparam int CNT_W = 6;

   localparam int CFG_W = 6;
   localparam int IDX_W = 2;

   localparam logic [CFG_W-1:0] LABEL_COLUMN_RESET   = 6'd18;
   localparam logic [CFG_W-1:0] OPERAND_COLUMN_RESET = 6'd29;

   // register indexes
   localparam logic [IDX_W-1:0] REG_LABEL_COLUMN   = 2'd0;
   localparam logic [IDX_W-1:0] REG_OPERAND_COLUMN = 2'd1;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_BANG  = 8'h21;

   // one queued command: a run of spaces, then optionally one byte
   typedef struct packed {
      logic [CNT_W-1:0] spaces;
      logic             has_byte;
      logic [7:0]       data;
      logic             stream_end;
   } lcr_cmd_type;

endpackage

`default_nettype wire

// ----- design/listing_column_realigner_core.sv -----
// Listing column realigner: each text line is copied verbatim up to the label
// column, then one field is copied, the blanks around it dropped, spaces pad to
// the operand column and later tabs become spaces; NUL ends the stream until
// reset. The front end takes one input byte per cycle whenever the command
// queue (QueueDepth entries, default 4) has room; the back end sends one result
// per cycle while the response side is ready, so an input byte that yields n
// results holds the back end for n results (up to 64 for a padding run, TabStop
// for a tab), and input stalls once the queue fills behind such a run. Bytes
// that yield no result (dropped blanks, anything after NUL) put nothing
// downstream, but they too wait while the queue is full. The configuration port
// is always ready; write it only while the block is idle.
`default_nettype none

module listing_column_realigner_core #(
   parameter int TabStop    = lcr_pkg::TAB_STOP,
   parameter int QueueDepth = lcr_pkg::QUEUE_DEPTH
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  [7:0]                 req_tdata,   // [7:0] in_byte
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [7:0] out_byte
   output logic                       rsp_tlast,   // last_of_run
   output logic                       rsp_tuser,   // [0] stream_end
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [lcr_pkg::IDX_W-1:0]  csr_index,
   input  wire  [lcr_pkg::CFG_W-1:0]  csr_data
);
   import lcr_pkg::*;

   lcr_cmd_type push_cmd, pop_cmd;
   logic        push_valid, push_ready;
   logic        pop_valid, pop_ready;

   assign csr_ready = 1'b1;

   lcr_front #(
      .TabStop (TabStop)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_data   (req_tdata),
      .csr_write  (csr_valid & csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   lcr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   lcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- design/lcr_front.sv -----
// lcr_front: accepts input bytes, tracks line phase and column, and turns
// each byte into at most one command for the back end; uses lcr_pkg
`default_nettype none

module lcr_front #(
   parameter int TabStop = lcr_pkg::TAB_STOP
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  [7:0]                      req_data,
   input  wire                             csr_write,
   input  wire  [lcr_pkg::IDX_W-1:0]       csr_index,
   input  wire  [lcr_pkg::CFG_W-1:0]       csr_data,
   output logic                            push_valid,
   input  wire                             push_ready,
   output lcr_pkg::lcr_cmd_type            push_cmd
);
   import lcr_pkg::*;

   localparam int TabW = $clog2(TabStop);

   localparam logic [2:0] PH_PREFIX      = 3'd0;
   localparam logic [2:0] PH_FIELD_START = 3'd1;
   localparam logic [2:0] PH_IN_FIELD    = 3'd2;
   localparam logic [2:0] PH_SKIP_PRE    = 3'd3;
   localparam logic [2:0] PH_SKIP_POST   = 3'd4;
   localparam logic [2:0] PH_OPERAND     = 3'd5;
   localparam logic [2:0] PH_DONE        = 3'd6;

   logic [CFG_W-1:0] label_ff;
   logic [CFG_W-1:0] operand_ff;
   logic [2:0]       phase_ff, phase_in, phase_eff;
   logic [7:0]       column_ff, column_in;
   logic [TabW-1:0]  col_mod_ff, col_mod_in;
   logic [TabW-1:0]  tab_off_ff, tab_off_in;
   logic             emit;
   logic             blank;
   logic [7:0]       col_step;
   logic [7:0]       col_pre;
   logic [7:0]       operand_wide;
   logic [7:0]       tab_run;
   logic             accept;

   function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] n);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, n};
      return sum[8] ? 8'hFF : sum[7:0];
   endfunction

   assign accept       = req_valid & req_ready;
   assign req_ready    = push_ready;
   assign push_valid   = req_valid & emit;
   assign blank        = req_data[7] | (req_data < CHAR_BANG);
   assign col_step     = sat_add(column_ff, 8'd1);
   assign operand_wide = {2'b00, operand_ff};
   assign tab_run      = 8'(TabStop) - 8'(tab_off_ff);

   always_comb begin
      phase_in   = phase_ff;
      column_in  = column_ff;
      col_mod_in = col_mod_ff;
      tab_off_in = tab_off_ff;
      emit       = 1'b0;
      push_cmd.spaces     = '0;
      push_cmd.has_byte   = 1'b1;
      push_cmd.data       = req_data;
      push_cmd.stream_end = 1'b0;
      col_pre    = column_ff;
      phase_eff  = (phase_ff == PH_PREFIX && column_ff >= {2'b00, label_ff}) ?
                   PH_FIELD_START : phase_ff;

      if (phase_ff == PH_DONE) begin
         phase_in = PH_DONE;
      end else if (req_data == CHAR_NUL) begin
         emit                = 1'b1;
         push_cmd.stream_end = 1'b1;
         phase_in            = PH_DONE;
      end else if (req_data == CHAR_NL) begin
         emit       = 1'b1;
         phase_in   = PH_PREFIX;
         column_in  = '0;
         col_mod_in = '0;
         tab_off_in = '0;
      end else begin
         phase_in = phase_eff;
         case (phase_eff)
            PH_PREFIX: begin
               emit = 1'b1;
               if (req_data == CHAR_TAB) begin
                  column_in  = sat_add(column_ff, 8'(TabStop) - 8'(col_mod_ff));
                  col_mod_in = '0;
               end else begin
                  column_in  = col_step;
                  col_mod_in = (col_mod_ff == TabW'(TabStop - 1)) ? '0 : col_mod_ff + 1'b1;
               end
            end
            PH_FIELD_START: begin
               if (blank) begin
                  phase_in = PH_SKIP_PRE;
               end else begin
                  emit     = 1'b1;
                  phase_in = PH_IN_FIELD;
               end
            end
            PH_IN_FIELD: begin
               if (blank) begin
                  phase_in = PH_SKIP_POST;
               end else begin
                  emit      = 1'b1;
                  column_in = col_step;
               end
            end
            PH_SKIP_PRE, PH_SKIP_POST: begin
               if (!blank) begin
                  // field ended on a blank: that blank still takes one column
                  col_pre = (phase_eff == PH_SKIP_POST) ? col_step : column_ff;
                  emit    = 1'b1;
                  push_cmd.spaces = (col_pre < operand_wide) ?
                                    CNT_W'(operand_wide - col_pre) : '0;
                  column_in  = operand_wide + 8'd2;
                  tab_off_in = TabW'(1);
                  phase_in   = PH_OPERAND;
               end
            end
            PH_OPERAND: begin
               emit = 1'b1;
               if (req_data == CHAR_TAB) begin
                  push_cmd.spaces   = CNT_W'(tab_run);
                  push_cmd.has_byte = 1'b0;
                  column_in         = sat_add(column_ff, tab_run);
                  tab_off_in        = '0;
               end else begin
                  column_in  = col_step;
                  tab_off_in = (tab_off_ff == TabW'(TabStop - 1)) ? '0 : tab_off_ff + 1'b1;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_ff   <= LABEL_COLUMN_RESET;
         operand_ff <= OPERAND_COLUMN_RESET;
         phase_ff   <= PH_PREFIX;
         column_ff  <= '0;
         col_mod_ff <= '0;
         tab_off_ff <= '0;
      end else begin
         if (csr_write && csr_index == REG_LABEL_COLUMN) begin
            label_ff <= csr_data;
         end
         if (csr_write && csr_index == REG_OPERAND_COLUMN) begin
            operand_ff <= csr_data;
         end
         if (accept) begin
            phase_ff   <= phase_in;
            column_ff  <= column_in;
            col_mod_ff <= col_mod_in;
            tab_off_ff <= tab_off_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/lcr_queue.sv -----
// lcr_queue: small command queue between front and back of the realigner
// register array with head and tail pointers; uses lcr_pkg
`default_nettype none

module lcr_queue #(
   parameter int Depth = lcr_pkg::QUEUE_DEPTH
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push_valid,
   output logic                  push_ready,
   input  lcr_pkg::lcr_cmd_type  push_cmd,
   output logic                  pop_valid,
   input  wire                   pop_ready,
   output lcr_pkg::lcr_cmd_type  pop_cmd
);
   import lcr_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   lcr_cmd_type     slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/lcr_back.sv -----
// lcr_back: expands queued commands into result bytes, one per cycle unless
// the consumer stalls, through a registered output stage; uses lcr_pkg
`default_nettype none

module lcr_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   pop_valid,
   output logic                  pop_ready,
   input  lcr_pkg::lcr_cmd_type  pop_cmd,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);
   import lcr_pkg::*;

   lcr_cmd_type work_ff;
   logic        work_valid_ff;
   logic        out_free;
   logic        gen;
   logic        finish;
   logic [7:0]  gen_data;
   logic        gen_last;
   logic        gen_end;

   assign out_free  = ~rsp_tvalid | rsp_tready;
   assign gen       = work_valid_ff & out_free;
   assign pop_ready = ~work_valid_ff | (gen & finish);

   always_comb begin
      if (work_ff.spaces != '0) begin
         gen_data = CHAR_SPACE;
         gen_last = (work_ff.spaces == CNT_W'(1)) & ~work_ff.has_byte;
         gen_end  = 1'b0;
         finish   = gen_last;
      end else begin
         gen_data = work_ff.data;
         gen_last = 1'b1;
         gen_end  = work_ff.stream_end;
         finish   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         work_ff <= pop_cmd;
      end else if (gen && !finish) begin
         work_ff.spaces <= work_ff.spaces - 1'b1;
      end
      if (gen) begin
         rsp_tdata <= gen_data;
         rsp_tlast <= gen_last;
         rsp_tuser <= gen_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_tvalid    <= 1'b0;
      end else begin
         if (pop_valid && pop_ready) begin
            work_valid_ff <= 1'b1;
         end else if (gen && finish) begin
            work_valid_ff <= 1'b0;
         end
         if (gen) begin
            rsp_tvalid <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   // stream end marker only on the final result of its byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("stream end without last flag");

   // every result ahead of the last one of a run is a padding space
   a_inner_is_space: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata == CHAR_SPACE)
      else $error("non-space result inside a run");

   // a command that has used up its spaces must still hold a byte
   a_work_has_result: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff && work_ff.spaces == '0 |-> work_ff.has_byte)
      else $error("empty command in back end");

   // an unfinished command stays in the working register
   a_work_holds: assert property (@(posedge clock) disable iff (reset)
      gen && !finish |=> work_valid_ff)
      else $error("command dropped before its last result");
`endif

endmodule

`default_nettype wire

// ----- test/listing_column_realigner_checker.sv -----
`timescale 1ns / 100ps
// listing_column_realigner_checker: watches the request, response and csr channels of the
// column realigner, predicts the realigned byte stream and compares every response transfer
// depends on lcr_pkg for register indexes, character codes and the tab stop
module listing_column_realigner_checker (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   input  wire                       req_tready,
   input  wire  [7:0]                req_tdata,   // [7:0] in_byte
   input  wire                       rsp_tvalid,
   input  wire                       rsp_tready,
   input  wire  [7:0]                rsp_tdata,   // [7:0] out_byte
   input  wire                       rsp_tlast,   // last_of_run
   input  wire                       rsp_tuser,   // [0] stream_end
   input  wire                       csr_valid,
   input  wire                       csr_ready,
   input  wire  [lcr_pkg::IDX_W-1:0] csr_index,
   input  wire  [lcr_pkg::CFG_W-1:0] csr_data,
   output int                        mismatches,
   output int                        expected_left
);
   import lcr_pkg::*;

   typedef enum logic [2:0] {
      LP_PREFIX,
      LP_FIELD_START,
      LP_IN_FIELD,
      LP_SKIP_LEAD,
      LP_SKIP_TRAIL,
      LP_OPERAND,
      LP_ENDED
   } line_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       stream_end;
   } out_char_type;

   out_char_type     expected_chars [$];
   out_char_type     held_char;
   out_char_type     oldest_char;
   out_char_type     seen_char;
   bit               held_valid;
   line_phase_type   line_phase;
   logic [7:0]       column;
   logic [3:0]       tab_offset;
   logic [CFG_W-1:0] label_column;
   logic [CFG_W-1:0] operand_column;

   function automatic logic [7:0] column_plus(input logic [7:0] c, input int n);
      int sum;
      sum = int'(c) + n;
      return (sum > 255) ? 8'd255 : 8'(sum);
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return (c < CHAR_BANG) || c[7];
   endfunction

   // one result is held back so that the final one of a run can get its last flag
   task automatic queue_char(input logic [7:0] b, input bit ends);
      if (held_valid)
         expected_chars.push_back(held_char);
      held_char  = {b, 1'b0, ends};
      held_valid = 1'b1;
   endtask

   task automatic realign_byte(input logic [7:0] c);
      int run;
      if (line_phase == LP_ENDED)
         return;
      if (line_phase == LP_PREFIX && column >= 8'(label_column))
         line_phase = LP_FIELD_START;

      if (c == CHAR_NUL) begin
         queue_char(c, 1'b1);
         line_phase = LP_ENDED;
      end else if (c == CHAR_NL) begin
         queue_char(c, 1'b0);
         line_phase = LP_PREFIX;
         column     = 8'd0;
         tab_offset = 4'd0;
      end else begin
         case (line_phase)
            LP_PREFIX: begin
               if (c == CHAR_TAB)
                  column = column_plus(column, TAB_STOP - int'(column) % TAB_STOP);
               else
                  column = column_plus(column, 1);
               queue_char(c, 1'b0);
            end
            LP_FIELD_START: begin
               if (is_blank(c)) begin
                  line_phase = LP_SKIP_LEAD;
               end else begin
                  queue_char(c, 1'b0);
                  line_phase = LP_IN_FIELD;
               end
            end
            LP_IN_FIELD: begin
               if (is_blank(c)) begin
                  line_phase = LP_SKIP_TRAIL;
               end else begin
                  queue_char(c, 1'b0);
                  column = column_plus(column, 1);
               end
            end
            LP_SKIP_LEAD, LP_SKIP_TRAIL: begin
               if (!is_blank(c)) begin
                  if (line_phase == LP_SKIP_TRAIL)
                     column = column_plus(column, 1);
                  while (column < 8'(operand_column)) begin
                     queue_char(CHAR_SPACE, 1'b0);
                     column = column_plus(column, 1);
                  end
                  queue_char(c, 1'b0);
                  column     = 8'(operand_column) + 8'd2;
                  tab_offset = 4'(1 % TAB_STOP);
                  line_phase = LP_OPERAND;
               end
            end
            default: begin
               if (c == CHAR_TAB) begin
                  run = TAB_STOP - int'(tab_offset);
                  repeat (run) queue_char(CHAR_SPACE, 1'b0);
                  column     = column_plus(column, run);
                  tab_offset = 4'd0;
               end else begin
                  queue_char(c, 1'b0);
                  column     = column_plus(column, 1);
                  tab_offset = 4'((int'(tab_offset) + 1) % TAB_STOP);
               end
            end
         endcase
      end

      if (held_valid) begin
         held_char.last_of_run = 1'b1;
         expected_chars.push_back(held_char);
         held_valid = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         label_column   = LABEL_COLUMN_RESET;
         operand_column = OPERAND_COLUMN_RESET;
         line_phase     = LP_PREFIX;
         column         = 8'd0;
         tab_offset     = 4'd0;
         held_valid     = 1'b0;
         mismatches     = 0;
         expected_chars.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_LABEL_COLUMN)
               label_column = csr_data;
            else if (csr_index == REG_OPERAND_COLUMN)
               operand_column = csr_data;
         end
         if (req_tvalid && req_tready)
            realign_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            seen_char = {rsp_tdata, rsp_tlast, rsp_tuser};
            if (expected_chars.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response transfer: byte %h last %b end %b",
                           seen_char.out_byte, seen_char.last_of_run, seen_char.stream_end);
            end else begin
               oldest_char = expected_chars.pop_front();
               if (seen_char.out_byte != oldest_char.out_byte
                     || seen_char.last_of_run != oldest_char.last_of_run
                     || seen_char.stream_end != oldest_char.stream_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response mismatch exp/got: byte %h/%h last %b/%b end %b/%b",
                              oldest_char.out_byte, seen_char.out_byte,
                              oldest_char.last_of_run, seen_char.last_of_run,
                              oldest_char.stream_end, seen_char.stream_end);
               end
            end
         end
      end
      expected_left = expected_chars.size();
   end

endmodule

// ----- test/listing_column_realigner_core_tb.sv -----
`timescale 1ns / 100ps
// listing_column_realigner_core_tb: clock, reset, register writes and byte stimulus for the
// column realigner with random idling on both sides; uses listing_column_realigner_checker
// for prediction and comparison, and lcr_pkg for constants
module listing_column_realigner_core_tb;
   import lcr_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;    // [7:0] in_byte
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [7:0]       rsp_tdata;    // [7:0] out_byte
   logic             rsp_tlast;    // last_of_run
   logic             rsp_tuser;    // [0] stream_end
   logic             csr_valid;
   logic             csr_ready;
   logic [IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_data;

   int               mismatches;
   int               expected_left;
   int               sent_items;
   int               idle_cycles;
   bit               quiet_tail;
   bit               hold_req;
   bit               hold_done;
   logic [CFG_W-1:0] label_setting;

   // blank ending a field, blank as first field byte, newline inside the field and the skip
   string opening_text = "x\tLB\377 o\tz\t\200\nabc !~\nqrsT\ndefG\t\n";

   listing_column_realigner_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   listing_column_realigner_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .mismatches    (mismatches),
      .expected_left (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // label and operand columns, then a write to an unused index that must be ignored
   task automatic write_config(input logic [CFG_W-1:0] label, input logic [CFG_W-1:0] operand);
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         case (k)
            0: begin
               csr_index <= REG_LABEL_COLUMN;
               csr_data  <= label;
            end
            1: begin
               csr_index <= REG_OPERAND_COLUMN;
               csr_data  <= operand;
            end
            default: begin
               csr_index <= REG_SPARE;
               csr_data  <= CFG_W'($urandom_range(0, 63));
            end
         endcase
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid     <= 1'b0;
      label_setting = label;
   endtask

   // valid stays high from one byte to the next unless a gap is taken
   task automatic send_byte(input logic [7:0] b);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_left != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // mostly well-formed lines: prefix, field, blanks, operand text, newline
   task automatic send_line();
      int         col;
      int         n;
      int         kind;
      logic [7:0] b;
      kind = $urandom_range(0, 11);
      if (kind == 0) begin
         n = $urandom_range(3, 15);
         repeat (n) send_byte(8'($urandom_range(1, 255)));
         return;
      end
      col = 0;
      while (col < int'(label_setting)) begin
         if ($urandom_range(0, 4) == 0) begin
            b = CHAR_TAB;
         end else begin
            b = 8'($urandom_range(1, 255));
            if (b == CHAR_NL)
               b = CHAR_SPACE;
         end
         if (b == CHAR_TAB)
            col = col + TAB_STOP - col % TAB_STOP;
         else
            col++;
         send_byte(b);
      end
      if (kind == 1) begin
         send_byte(CHAR_NL);
         return;
      end
      n = (kind == 4) ? 0 : $urandom_range(1, 6);
      repeat (n) send_byte(8'($urandom_range(33, 127)));
      if (kind == 2) begin
         send_byte(CHAR_NL);
         return;
      end
      n = (kind == 4) ? $urandom_range(1, 3) : $urandom_range(0, 3);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: b = CHAR_SPACE;
            1: b = CHAR_TAB;
            2: b = 8'($urandom_range(128, 255));
            default: begin
               b = 8'($urandom_range(1, 32));
               if (b == CHAR_NL)
                  b = CHAR_SPACE;
            end
         endcase
         send_byte(b);
      end
      if (kind == 3) begin
         send_byte(CHAR_NL);
         return;
      end
      send_byte(8'($urandom_range(33, 127)));
      n = $urandom_range(0, 12);
      repeat (n) begin
         if ($urandom_range(0, 2) == 0) begin
            b = CHAR_TAB;
         end else begin
            b = 8'($urandom_range(1, 255));
            if (b == CHAR_NL)
               b = CHAR_SPACE;
         end
         send_byte(b);
      end
      send_byte(CHAR_NL);
   endtask

   task automatic fill_to(input int goal);
      while (sent_items < goal) send_line();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      csr_valid  = 1'b0;
      csr_index  = REG_LABEL_COLUMN;
      csr_data   = '0;
      sent_items = 0;
      quiet_tail = 1'b0;
      hold_req   = 1'b0;
      label_setting = LABEL_COLUMN_RESET;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      write_config(6'd3, 6'd14);
      for (int i = 0; i < opening_text.len(); i++)
         send_byte(opening_text[i]);

      settle();
      write_config(LABEL_COLUMN_RESET, OPERAND_COLUMN_RESET);
      fill_to(70);
      settle();
      write_config(6'd0, 6'd0);
      fill_to(110);
      settle();
      write_config(6'd62, 6'd63);
      hold_req = 1'b1;
      fill_to(160);
      settle();
      write_config(6'd1, 6'd2);
      fill_to(195);
      settle();
      write_config(6'd63, 6'd1);
      fill_to(225);
      settle();
      write_config(CFG_W'($urandom_range(0, 63)), CFG_W'($urandom_range(0, 63)));
      quiet_tail = 1'b1;
      fill_to(245);

      // end of stream, then bytes that must produce nothing
      send_byte(CHAR_NUL);
      send_byte(CHAR_NL);
      send_byte("A");
      send_byte(CHAR_NUL);
      settle();

      if (mismatches == 0 && expected_left == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // response side: short random stalls, one long hold-off while the sender keeps going
   initial begin
      rsp_tready = 1'b0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
            || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
